/* rtl/chs_pkg.sv */
// Shared constants for the cosine hemisphere sampler pipeline.
// Fixed point format, angle and density scale factors, series divisors.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

	localparam int IN_FRAC_BITS  = 16;
	localparam int DIR_FRAC_BITS = 14;

	localparam int Q = 30;
	localparam logic [30:0] ONE_Q = 31'h4000_0000;
	localparam logic [29:0] PI4_Q30 = 30'd843314857;
	localparam logic [28:0] INV_PI_Q30 = 29'd341782638;

	localparam int N_COS = 5;
	localparam int N_SIN = 4;
	localparam int COS_K [N_COS] = '{90, 56, 30, 12, 2};
	localparam int SIN_K [N_SIN] = '{72, 42, 20, 6};

endpackage

`default_nettype wire

/* rtl/chs_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Carries a side word alongside each division. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module chs_div #(
	parameter int NW = 48,
	parameter int DW = 17,
	parameter int QW = 31,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] aux,
	output logic               res_vld,
	output logic [QW-1:0]      quo,
	output logic [SW-1:0]      res_aux
);

	localparam int XW = DW + QW;

	logic [XW-1:0] rem_s [QW];
	logic [DW-1:0] d_s   [QW];
	logic [QW-1:0] q_s   [QW];
	logic [SW-1:0] aux_s [QW];
	logic          v_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		localparam int J = QW - 1 - k;
		logic [XW-1:0] rin;
		logic [DW-1:0] din;
		logic [QW-1:0] qin;
		logic [SW-1:0] ain;
		logic          vin;
		logic [XW-1:0] dsh;
		logic          ge;

		if (k == 0) begin : g_first
			assign rin = XW'(num);
			assign din = den;
			assign qin = '0;
			assign ain = aux;
			assign vin = vld;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign din = d_s[k-1];
			assign qin = q_s[k-1];
			assign ain = aux_s[k-1];
			assign vin = v_s[k-1];
		end

		assign dsh = XW'(din) << J;
		assign ge  = rin >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rin - dsh : rin;
				d_s[k]   <= din;
				q_s[k]   <= {qin[QW-2:0], ge};
				aux_s[k] <= ain;
			end
		end
	end

	assign res_vld = v_s[QW-1];
	assign quo     = q_s[QW-1];
	assign res_aux = aux_s[QW-1];

endmodule

`default_nettype wire

/* rtl/chs_sqrt.sv */
// Pipelined integer square root, one root bit per stage (floor result).
// Carries a side word alongside each radicand. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module chs_sqrt #(
	parameter int B  = 30,
	parameter int SW = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld,
	input  wire logic [2*B-1:0] rad,
	input  wire logic [SW-1:0]  aux,
	output logic                res_vld,
	output logic [B-1:0]        root,
	output logic [SW-1:0]       res_aux
);

	logic [B+1:0]   rem_s [B];
	logic [B-1:0]   q_s   [B];
	logic [2*B-1:0] r_s   [B];
	logic [SW-1:0]  aux_s [B];
	logic           v_s   [B];

	for (genvar k = 0; k < B; k++) begin : g_st
		logic [B+1:0]   rin;
		logic [B-1:0]   qin;
		logic [2*B-1:0] radin;
		logic [SW-1:0]  ain;
		logic           vin;
		logic [B+1:0]   remn;
		logic [B+1:0]   trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rin   = '0;
			assign qin   = '0;
			assign radin = rad;
			assign ain   = aux;
			assign vin   = vld;
		end else begin : g_next
			assign rin   = rem_s[k-1];
			assign qin   = q_s[k-1];
			assign radin = r_s[k-1];
			assign ain   = aux_s[k-1];
			assign vin   = v_s[k-1];
		end

		assign remn  = {rin[B-1:0], radin[2*B-1:2*B-2]};
		assign trial = {qin, 2'b01};
		assign ge    = remn >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? remn - trial : remn;
				q_s[k]   <= {qin[B-2:0], ge};
				r_s[k]   <= {radin[2*B-3:0], 2'b00};
				aux_s[k] <= ain;
			end
		end
	end

	assign res_vld = v_s[B-1];
	assign root    = q_s[B-1];
	assign res_aux = aux_s[B-1];

endmodule

`default_nettype wire

/* rtl/chs_poly_step.sv */
// One Horner step of the sine and cosine series: t' = 1 - ((a2 * t) >> Q) / K.
// Three stages: product, reciprocal multiply, correct and subtract. Uses chs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chs_poly_step #(
	parameter int K  = 2,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld,
	input  wire logic [29:0]   a2,
	input  wire logic [30:0]   t,
	input  wire logic [SW-1:0] aux,
	output logic               res_vld,
	output logic [29:0]        res_a2,
	output logic [30:0]        res_t,
	output logic [SW-1:0]      res_aux
);

	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);

	logic [60:0]   prod;
	logic [62:0]   pr;
	logic [30:0]   qk;
	logic [30:0]   rm;
	logic [30:0]   qc;

	logic [30:0]   p_s1, p_s2;
	logic [30:0]   q0_s2;
	logic [30:0]   t_s3;
	logic [29:0]   a2_s1, a2_s2, a2_s3;
	logic [SW-1:0] aux_s1, aux_s2, aux_s3;
	logic          v_s1, v_s2, v_s3;

	assign prod = 61'(a2) * 61'(t);
	assign pr   = 63'(p_s1) * 63'(RECIP);
	assign qk   = 31'(q0_s2) * 31'(K);
	assign rm   = p_s2 - qk;
	assign qc   = (rm >= 31'(K)) ? q0_s2 + 31'd1 : q0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= prod[60:30];
			a2_s1  <= a2;
			aux_s1 <= aux;
			p_s2   <= p_s1;
			q0_s2  <= pr[62:32];
			a2_s2  <= a2_s1;
			aux_s2 <= aux_s1;
			t_s3   <= chs_pkg::ONE_Q - qc;
			a2_s3  <= a2_s2;
			aux_s3 <= aux_s2;
		end
	end

	assign res_vld = v_s3;
	assign res_a2  = a2_s3;
	assign res_t   = t_s3;
	assign res_aux = aux_s3;

endmodule

`default_nettype wire

/* rtl/cosine_hemisphere_sampler.sv */
// Top level of the cosine hemisphere sampler: concentric disk mapping, lift,
// normalize and density. Uses chs_pkg, chs_div, chs_sqrt and chs_poly_step.
//
// Takes one (u_coord, v_coord) word per cycle and gives one direction and
// density word per cycle while the output is not stalled. Its pipeline depth
// comes from the bit-per-stage ratio divider, the two square roots, the three
// normalizing dividers and the 15-stage cosine series. The whole pipeline
// holds when a finished word is not taken, so in_ready follows out_ready
// whenever the output register is full.
`timescale 1ns / 1ps
`default_nettype none

module cosine_hemisphere_sampler #(
	parameter int IN_FRAC_BITS  = chs_pkg::IN_FRAC_BITS,
	parameter int DIR_FRAC_BITS = chs_pkg::DIR_FRAC_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] u_coord,
	input  wire logic [15:0] v_coord,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      dir_x,
	output logic [15:0]      dir_y,
	output logic [14:0]      dir_z,
	output logic [14:0]      density
);

	localparam int IFB = IN_FRAC_BITS;
	localparam int SH  = chs_pkg::Q - DIR_FRAC_BITS;
	localparam int MW  = DIR_FRAC_BITS + 1;
	localparam logic [IFB:0] FULL = (IFB+1)'(1) << IFB;
	localparam logic [30:0] HALF = 31'(1) << (SH - 1);

	typedef struct packed {
		logic [IFB:0] major;
		logic         xmaj;
		logic         ctr;
		logic         sx;
		logic         sy;
	} geo_t;

	typedef struct packed {
		logic [30:0] mx;
		logic [30:0] my;
		logic [31:0] d2;
		logic        sx;
		logic        sy;
	} zaux_t;

	typedef struct packed {
		logic [30:0] mx;
		logic [30:0] my;
		logic [30:0] z;
		logic        sx;
		logic        sy;
	} laux_t;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// input stage
	logic [31:0]     u32, v32;
	logic [IFB-1:0]  uf, vf;
	logic [IFB:0]    ax, ay;
	logic [IFB+10:0] axk, ayk;
	logic            near_x, near_y;

	assign u32    = {16'd0, u_coord};
	assign v32    = {16'd0, v_coord};
	assign uf     = u32[IFB-1:0];
	assign vf     = v32[IFB-1:0];
	assign ax     = uf[IFB-1] ? {uf, 1'b0} - FULL : FULL - {uf, 1'b0};
	assign ay     = vf[IFB-1] ? {vf, 1'b0} - FULL : FULL - {vf, 1'b0};
	assign axk    = (IFB+11)'(ax) * (IFB+11)'(1000);
	assign ayk    = (IFB+11)'(ay) * (IFB+11)'(1000);
	assign near_x = axk < (IFB+11)'(FULL);
	assign near_y = ayk < (IFB+11)'(FULL);

	geo_t         geo_s1;
	logic [IFB:0] minor_s1;
	logic         v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.xmaj  <= ax > ay;
			geo_s1.major <= (ax > ay) ? ax : ay;
			minor_s1     <= (ax > ay) ? ay : ax;
			geo_s1.ctr   <= near_x && near_y;
			geo_s1.sx    <= !uf[IFB-1];
			geo_s1.sy    <= !vf[IFB-1];
		end
	end

	// ratio minor / major
	logic [30:0] s_quo;
	geo_t        geo_d;
	logic        v_d;

	chs_div #(.NW(IFB + 31), .DW(IFB + 1), .QW(31), .SW($bits(geo_t))) u_ratio (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(v_s1), .num({minor_s1, 30'd0}), .den(geo_s1.major), .aux(geo_s1),
		.res_vld(v_d), .quo(s_quo), .res_aux(geo_d)
	);

	// angle and its square
	logic [60:0] ap;
	logic [59:0] asq;
	logic [29:0] a_s2, a_s3, a2_s3;
	geo_t        geo_s2, geo_s3;
	logic        v_s2, v_s3;

	assign ap  = 61'(chs_pkg::PI4_Q30) * 61'(s_quo);
	assign asq = 60'(a_s2) * 60'(a_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_d;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= ap[59:30];
			geo_s2 <= geo_d;
			a_s3   <= a_s2;
			a2_s3  <= asq[59:30];
			geo_s3 <= geo_s2;
		end
	end

	// cosine series
	logic [30:0] ct   [chs_pkg::N_COS];
	logic [29:0] ca2  [chs_pkg::N_COS];
	geo_t        caux [chs_pkg::N_COS];
	logic        cv   [chs_pkg::N_COS];

	for (genvar k = 0; k < chs_pkg::N_COS; k++) begin : g_cos
		logic [30:0] t_in;
		logic [29:0] a2_in;
		geo_t        aux_in;
		logic        v_in;

		if (k == 0) begin : g_first
			assign t_in   = chs_pkg::ONE_Q;
			assign a2_in  = a2_s3;
			assign aux_in = geo_s3;
			assign v_in   = v_s3;
		end else begin : g_next
			assign t_in   = ct[k-1];
			assign a2_in  = ca2[k-1];
			assign aux_in = caux[k-1];
			assign v_in   = cv[k-1];
		end

		chs_poly_step #(.K(chs_pkg::COS_K[k]), .SW($bits(geo_t))) u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld(v_in), .a2(a2_in), .t(t_in), .aux(aux_in),
			.res_vld(cv[k]), .res_a2(ca2[k]), .res_t(ct[k]), .res_aux(caux[k])
		);
	end

	// sine series
	logic [30:0] st   [chs_pkg::N_SIN];
	logic [29:0] sa2  [chs_pkg::N_SIN];
	logic [29:0] saux [chs_pkg::N_SIN];
	logic        sv   [chs_pkg::N_SIN];

	for (genvar k = 0; k < chs_pkg::N_SIN; k++) begin : g_sin
		logic [30:0] t_in;
		logic [29:0] a2_in;
		logic [29:0] aux_in;
		logic        v_in;

		if (k == 0) begin : g_first
			assign t_in   = chs_pkg::ONE_Q;
			assign a2_in  = a2_s3;
			assign aux_in = a_s3;
			assign v_in   = v_s3;
		end else begin : g_next
			assign t_in   = st[k-1];
			assign a2_in  = sa2[k-1];
			assign aux_in = saux[k-1];
			assign v_in   = sv[k-1];
		end

		chs_poly_step #(.K(chs_pkg::SIN_K[k]), .SW(30)) u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld(v_in), .a2(a2_in), .t(t_in), .aux(aux_in),
			.res_vld(sv[k]), .res_a2(sa2[k]), .res_t(st[k]), .res_aux(saux[k])
		);
	end

	// sine final product, then align with the longer cosine series
	logic [60:0] snp;
	logic [30:0] sn_s4, sn_s5, sn_s6;
	logic        v_sn_s4, v_sn_s5, v_sn_s6;

	assign snp = 61'(saux[chs_pkg::N_SIN-1]) * 61'(st[chs_pkg::N_SIN-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn_s4 <= 1'b0;
			v_sn_s5 <= 1'b0;
			v_sn_s6 <= 1'b0;
		end else if (en) begin
			v_sn_s4 <= sv[chs_pkg::N_SIN-1];
			v_sn_s5 <= v_sn_s4;
			v_sn_s6 <= v_sn_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s4 <= snp[60:30];
			sn_s5 <= sn_s4;
			sn_s6 <= sn_s5;
		end
	end

	// disk point
	geo_t          gc;
	logic [30:0]   cosv;
	logic [IFB+31:0] cp, sp;
	logic [30:0]   cm, sm;
	logic [30:0]   mx_s7, my_s7;
	logic          sx_s7, sy_s7, v_s7;

	assign gc   = caux[chs_pkg::N_COS-1];
	assign cosv = ct[chs_pkg::N_COS-1];
	assign cp   = (IFB+32)'(gc.major) * (IFB+32)'(cosv);
	assign sp   = (IFB+32)'(gc.major) * (IFB+32)'(sn_s6);
	assign cm   = gc.ctr ? 31'd0 : cp[IFB+30:IFB];
	assign sm   = gc.ctr ? 31'd0 : sp[IFB+30:IFB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= cv[chs_pkg::N_COS-1] && v_sn_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s7 <= gc.xmaj ? cm : sm;
			my_s7 <= gc.xmaj ? sm : cm;
			sx_s7 <= gc.sx;
			sy_s7 <= gc.sy;
		end
	end

	// squares and radicand for z
	logic [61:0] mxx, myy;
	logic [30:0] sqx_s8, sqy_s8, mx_s8, my_s8;
	logic        sx_s8, sy_s8, v_s8;
	logic [31:0] d2;
	logic [30:0] rz;
	zaux_t       zaux_s9;
	logic [61:0] radz_s9;
	logic        v_s9;

	assign mxx = 62'(mx_s7) * 62'(mx_s7);
	assign myy = 62'(my_s7) * 62'(my_s7);
	assign d2  = 32'(sqx_s8) + 32'(sqy_s8);
	assign rz  = chs_pkg::ONE_Q - d2[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s8     <= mxx[60:30];
			sqy_s8     <= myy[60:30];
			mx_s8      <= mx_s7;
			my_s8      <= my_s7;
			sx_s8      <= sx_s7;
			sy_s8      <= sy_s7;
			radz_s9    <= (d2 >= 32'(chs_pkg::ONE_Q)) ? 62'd0 : 62'({rz, 30'd0});
			zaux_s9.mx <= mx_s8;
			zaux_s9.my <= my_s8;
			zaux_s9.d2 <= d2;
			zaux_s9.sx <= sx_s8;
			zaux_s9.sy <= sy_s8;
		end
	end

	logic [30:0] zr;
	zaux_t       zaux_d;
	logic        v_z;

	chs_sqrt #(.B(31), .SW($bits(zaux_t))) u_sqrt_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(v_s9), .rad(radz_s9), .aux(zaux_s9),
		.res_vld(v_z), .root(zr), .res_aux(zaux_d)
	);

	// squared length
	logic [61:0] zz;
	logic [31:0] sum_s10;
	laux_t       laux_s10;
	logic        v_s10;

	assign zz = 62'(zr) * 62'(zr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s10     <= zaux_d.d2 + zz[61:30];
			laux_s10.mx <= zaux_d.mx;
			laux_s10.my <= zaux_d.my;
			laux_s10.z  <= zr;
			laux_s10.sx <= zaux_d.sx;
			laux_s10.sy <= zaux_d.sy;
		end
	end

	logic [30:0] len;
	laux_t       laux_d;
	logic        v_len;

	chs_sqrt #(.B(31), .SW($bits(laux_t))) u_sqrt_len (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(v_s10), .rad({sum_s10, 30'd0}), .aux(laux_s10),
		.res_vld(v_len), .root(len), .res_aux(laux_d)
	);

	// normalize numerators
	logic [61:0] hl;
	logic [61:0] numx_s11, numy_s11, numz_s11;
	logic [30:0] len_s11;
	logic        lz_s11, sx_s11, sy_s11, v_s11;

	assign hl = 62'(len >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_len;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s11 <= 62'({laux_d.mx, 30'd0}) + hl;
			numy_s11 <= 62'({laux_d.my, 30'd0}) + hl;
			numz_s11 <= 62'({laux_d.z, 30'd0}) + hl;
			len_s11  <= len;
			lz_s11   <= len == 31'd0;
			sx_s11   <= laux_d.sx;
			sy_s11   <= laux_d.sy;
		end
	end

	logic [31:0] qx, qy, qz;
	logic        sx_d, sy_d, lz_d;
	logic        vdx, vdy, vdz;

	chs_div #(.NW(62), .DW(31), .QW(32), .SW(1)) u_norm_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(v_s11), .num(numx_s11), .den(len_s11), .aux(sx_s11),
		.res_vld(vdx), .quo(qx), .res_aux(sx_d)
	);

	chs_div #(.NW(62), .DW(31), .QW(32), .SW(1)) u_norm_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(v_s11), .num(numy_s11), .den(len_s11), .aux(sy_s11),
		.res_vld(vdy), .quo(qy), .res_aux(sy_d)
	);

	chs_div #(.NW(62), .DW(31), .QW(32), .SW(1)) u_norm_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(v_s11), .num(numz_s11), .den(len_s11), .aux(lz_s11),
		.res_vld(vdz), .quo(qz), .res_aux(lz_d)
	);

	// clamp, round and density product
	logic [30:0]   nx, ny, nz;
	logic [30:0]   rx, ry, rzr;
	logic [MW-1:0] magx_s12, magy_s12, magz_s12;
	logic [59:0]   pdfp_s12;
	logic          sx_s12, sy_s12, v_s12;

	assign nx  = lz_d ? 31'd0 :
		((qx > 32'(chs_pkg::ONE_Q)) ? chs_pkg::ONE_Q : qx[30:0]);
	assign ny  = lz_d ? 31'd0 :
		((qy > 32'(chs_pkg::ONE_Q)) ? chs_pkg::ONE_Q : qy[30:0]);
	assign nz  = (lz_d || (qz > 32'(chs_pkg::ONE_Q))) ? chs_pkg::ONE_Q : qz[30:0];
	assign rx  = nx + HALF;
	assign ry  = ny + HALF;
	assign rzr = nz + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= vdx && vdy && vdz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s12 <= rx[30:SH];
			magy_s12 <= ry[30:SH];
			magz_s12 <= rzr[30:SH];
			pdfp_s12 <= 60'(nz) * 60'(chs_pkg::INV_PI_Q30);
			sx_s12   <= sx_d;
			sy_s12   <= sy_d;
		end
	end

	// sign, saturate, output register
	logic [31:0] mx32, my32, mz32;
	logic [31:0] nmx, nmy;
	logic [59:0] pr;
	logic [15:0] pv;
	logic [15:0] dir_x_s13, dir_y_s13;
	logic [14:0] dir_z_s13, density_s13;
	logic        v_s13;

	assign mx32 = 32'(magx_s12);
	assign my32 = 32'(magy_s12);
	assign mz32 = 32'(magz_s12);
	assign nmx  = 32'd0 - mx32;
	assign nmy  = 32'd0 - my32;
	assign pr   = pdfp_s12 + (60'd1 << 43);
	assign pv   = pr[59:44];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sx_s12) begin
				dir_x_s13 <= (mx32 > 32'd32768) ? 16'h8000 : nmx[15:0];
			end else begin
				dir_x_s13 <= (mx32 > 32'd32767) ? 16'h7fff : mx32[15:0];
			end
			if (sy_s12) begin
				dir_y_s13 <= (my32 > 32'd32768) ? 16'h8000 : nmy[15:0];
			end else begin
				dir_y_s13 <= (my32 > 32'd32767) ? 16'h7fff : my32[15:0];
			end
			dir_z_s13   <= (mz32 > 32'd32767) ? 15'h7fff : mz32[14:0];
			density_s13 <= (pv > 16'd32767) ? 15'h7fff : pv[14:0];
		end
	end

	assign out_valid = v_s13;
	assign dir_x     = dir_x_s13;
	assign dir_y     = dir_y_s13;
	assign dir_z     = dir_z_s13;
	assign density   = density_s13;

`ifndef SYNTHESIS
	a_series_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		cv[chs_pkg::N_COS-1] == v_sn_s6)
		else $error("sine and cosine series out of step");

	a_norm_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(vdx == vdz) && (vdy == vdz))
		else $error("normalizing divider lanes out of step");

	a_density_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> density <= 15'd20861)
		else $error("density above the value at the pole");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_s12) |=> v_s12 && $stable(magz_s12))
		else $error("pipeline stage moved while the output was held");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for cosine_hemisphere_sampler: a scoreboard class predicts
// the direction and density of each accepted sample pair and checks every result word.
// Depends on chs_pkg and the RTL of cosine_hemisphere_sampler.
`timescale 1ns / 1ps

typedef struct {
	logic [15:0] dx;
	logic [15:0] dy;
	logic [14:0] dz;
	logic [14:0] pdf;
} dir_word_t;

class hemi_scoreboard;
	dir_word_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > n) bt >>= 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned sin_q(longint unsigned a);
		longint unsigned a2, t, one;
		one = 64'd1 << 30;
		a2 = (a * a) >> 30;
		t = one - a2 / chs_pkg::SIN_K[0];
		for (int i = 1; i < chs_pkg::N_SIN; i++) t = one - ((a2 * t) >> 30) / chs_pkg::SIN_K[i];
		return (a * t) >> 30;
	endfunction

	function automatic longint unsigned cos_q(longint unsigned a);
		longint unsigned a2, t, one;
		one = 64'd1 << 30;
		a2 = (a * a) >> 30;
		t = one - a2 / chs_pkg::COS_K[0];
		for (int i = 1; i < chs_pkg::N_COS; i++) t = one - ((a2 * t) >> 30) / chs_pkg::COS_K[i];
		return t;
	endfunction

	function automatic longint unsigned unit_q(longint unsigned m, longint unsigned len);
		longint unsigned n;
		n = ((m << 30) + (len >> 1)) / len;
		return (n > (64'd1 << 30)) ? (64'd1 << 30) : n;
	endfunction

	function automatic longint fix_dir(longint unsigned n, bit neg, longint lo, longint hi);
		longint v;
		v = longint'((n + (64'd1 << 15)) >> 16);
		if (neg) v = -v;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	function void note_input(logic [15:0] u, logic [15:0] v);
		longint ox, oy;
		longint unsigned ax, ay, mx, my, major, minor, s, a, c, sn, d2, z, len, nx, ny, nz, pdf;
		bit xmajor;
		dir_word_t w;
		ox = 2 * longint'(u) - 65536;
		oy = 2 * longint'(v) - 65536;
		ax = ox < 0 ? -ox : ox;
		ay = oy < 0 ? -oy : oy;
		mx = 0;
		my = 0;
		if (!(ax * 1000 < 65536 && ay * 1000 < 65536)) begin
			xmajor = ax > ay;
			major = xmajor ? ax : ay;
			minor = xmajor ? ay : ax;
			if (major != 0) begin
				s = (minor << 30) / major;
				a = (longint'(chs_pkg::PI4_Q30) * s) >> 30;
				c = (major * cos_q(a)) >> 16;
				sn = (major * sin_q(a)) >> 16;
				mx = xmajor ? c : sn;
				my = xmajor ? sn : c;
			end
		end
		d2 = ((mx * mx) >> 30) + ((my * my) >> 30);
		z = (d2 >= (64'd1 << 30)) ? 0 : isqrt(((64'd1 << 30) - d2) << 30);
		len = isqrt((d2 + ((z * z) >> 30)) << 30);
		if (len == 0) begin
			nx = 0;
			ny = 0;
			nz = 64'd1 << 30;
		end else begin
			nx = unit_q(mx, len);
			ny = unit_q(my, len);
			nz = unit_q(z, len);
		end
		w.dx = 16'(fix_dir(nx, ox < 0, -32768, 32767));
		w.dy = 16'(fix_dir(ny, oy < 0, -32768, 32767));
		w.dz = 15'(fix_dir(nz, 1'b0, 0, 32767));
		pdf = (nz * longint'(chs_pkg::INV_PI_Q30) + (64'd1 << 43)) >> 44;
		if (pdf > 32767) pdf = 32767;
		w.pdf = 15'(pdf);
		pending.push_back(w);
	endfunction

	function void check_result(logic [15:0] dx, logic [15:0] dy, logic [14:0] dz,
		logic [14:0] pdf);
		dir_word_t w;
		if (pending.size() == 0) begin
			$display("%0t: unexpected word dx=%0d dy=%0d dz=%0d pdf=%0d", $time,
				$signed(dx), $signed(dy), dz, pdf);
			errors++;
			return;
		end
		w = pending.pop_front();
		if (dx !== w.dx) begin
			$display("%0t: dir_x expected %0d actual %0d", $time, $signed(w.dx), $signed(dx));
			errors++;
		end
		if (dy !== w.dy) begin
			$display("%0t: dir_y expected %0d actual %0d", $time, $signed(w.dy), $signed(dy));
			errors++;
		end
		if (dz !== w.dz) begin
			$display("%0t: dir_z expected %0d actual %0d", $time, w.dz, dz);
			errors++;
		end
		if (pdf !== w.pdf) begin
			$display("%0t: density expected %0d actual %0d", $time, w.pdf, pdf);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int NUM_RANDOM = 1000;
	localparam int CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [15:0] u_coord;
	logic [15:0] v_coord;
	logic out_valid;
	logic out_ready;
	logic [15:0] dir_x;
	logic [15:0] dir_y;
	logic [14:0] dir_z;
	logic [14:0] density;

	hemi_scoreboard sb = new();
	int cycles = 0;

	cosine_hemisphere_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.u_coord(u_coord),
		.v_coord(v_coord),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.density(density)
	);

	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(u_coord, v_coord);
		if (arst_n && out_valid && out_ready) sb.check_result(dir_x, dir_y, dir_z, density);
	end

	task automatic send_word(logic [15:0] u, logic [15:0] v);
		in_valid <= 1'b1;
		u_coord <= u;
		v_coord <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_pair(output logic [15:0] u, output logic [15:0] v);
		case ($urandom_range(0, 9))
			0: begin
				u = 16'(32768 + $urandom_range(0, 80) - 40);
				v = 16'(32768 + $urandom_range(0, 80) - 40);
			end
			1: begin
				u = 16'($urandom);
				v = ($urandom_range(0, 1) == 1) ? u : 16'(65536 - u);
			end
			2: begin
				u = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 15)) : 16'($urandom_range(65520, 65535));
				v = 16'($urandom);
			end
			default: begin
				u = 16'($urandom);
				v = 16'($urandom);
			end
		endcase
	endtask

	initial begin
		logic [15:0] du [] = '{0, 65535, 32768, 32800, 32801, 32768, 0, 32768, 65535, 0,
			40000, 40000, 25536, 1, 32767, 65535, 0, 32736};
		logic [15:0] dv [] = '{0, 65535, 32768, 32768, 32768, 32800, 32768, 0, 0, 65535,
			40000, 25536, 40000, 65535, 32769, 32768, 1, 32736};
		logic [15:0] u, v;
		int burst;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		u_coord <= '0;
		v_coord <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (du[i]) send_word(du[i], dv[i]);
		idle_gap();
		for (int n = 0; n < NUM_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
				random_pair(u, v);
				send_word(u, v);
			end
			idle_gap();
		end
		in_valid <= 1'b0;
		wait (sb.pending.size() == 0);
		repeat (300) @(posedge clk);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		int mode;
		out_ready <= 1'b0;
		@(posedge arst_n);
		repeat (60) begin
			@(posedge clk);
			out_ready <= $urandom_range(0, 1);
		end
		@(posedge clk);
		out_ready <= 1'b0;
		repeat (600) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(50, 300)) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end
endmodule
